// ----- src/rrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types, codes and helpers of the rectangle raster painter.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int MaxSide  = 256;
  localparam int SideW    = $clog2(MaxSide);
  localparam int AddrW    = 2 * SideW;
  localparam int Depth    = MaxSide * MaxSide;
  localparam int SizeW    = 9;
  localparam int FixW     = 20;
  localparam int CoordW   = FixW + 1 - 8;
  localparam int CfgIdxW  = 2;

  // command codes
  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdDraw  = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  // status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadRect  = 2'd1;
  localparam logic [1:0] StatusOutRange = 2'd2;

  // shape bytes
  localparam logic [7:0] ShapeOutline = 8'd114;
  localparam logic [7:0] ShapeFilled  = 8'd82;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWidth      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBackground = 2'd2;

  typedef enum logic [1:0] {
    OpClear,
    OpDraw,
    OpRead,
    OpReply
  } op_kind_e;

  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    logic [7:0]       background;
  } cfg_t;

  // Decoded command passed from the front end to the back end.
  // Draw bounds are integer pixel coordinates of the first and last covered
  // column and row.
  typedef struct packed {
    op_kind_e                 kind;
    logic [1:0]               status;
    logic                     outline;
    logic [7:0]               paint;
    logic signed [CoordW-1:0] x_lo;
    logic signed [CoordW-1:0] x_hi;
    logic signed [CoordW-1:0] y_lo;
    logic signed [CoordW-1:0] y_hi;
    logic [AddrW-1:0]         rd_addr;
  } op_t;

  // size register clamped into 1..MaxSide
  function automatic logic [SizeW-1:0] side_in_use(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeW'(MaxSide)) begin
      r = SizeW'(MaxSide);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/rrp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_if
// Valid/ready channels of the painter: commands, results, configuration.
// ----------------------------------------------------------------------------
interface rrp_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [7:0]        shape_kind;
  logic signed [19:0] rect_x;
  logic signed [19:0] rect_y;
  logic signed [19:0] rect_width;
  logic signed [19:0] rect_height;
  logic [7:0]        paint_byte;
  logic [7:0]        pixel_col;
  logic [7:0]        pixel_row;

  modport source (
    output valid, command, shape_kind, rect_x, rect_y, rect_width, rect_height,
           paint_byte, pixel_col, pixel_row,
    input  ready
  );
  modport sink (
    input  valid, command, shape_kind, rect_x, rect_y, rect_width, rect_height,
           paint_byte, pixel_col, pixel_row,
    output ready
  );
endinterface

interface rrp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink (input valid, status, pixel_value, output ready);
endinterface

interface rrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/rectangle_raster_painter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rectangle_raster_painter
// Byte-per-pixel canvas painter: clear, rectangle draw and pixel read.
// ----------------------------------------------------------------------------
//  channel  dir  modport  content
//  cmd_i    in   sink     command, shape, Q12.8 rectangle, colour, read pos
//  res_o    out  source   status, pixel_value
//  cfg_i    in   sink     index 0 width, 1 height, 2 background byte
//
//  A clear sweeps the whole canvas (one canvas write per cycle), a draw sweeps
//  the columns and rows in use, a read passes a registered read state, bad and
//  unused commands go straight to the result; the result then holds until
//  taken. One write and one read port on the canvas; the sweep sets the rate.
//  A two-entry queue keeps accepting commands while the back end works, until
//  full. Reset does not touch the canvas: a pixel is valid once a clear wrote it.
// ----------------------------------------------------------------------------
module rectangle_raster_painter
  import rrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrp_cmd_if.sink   cmd_i,
  rrp_res_if.source res_o,
  rrp_cfg_if.sink   cfg_i
);

  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  logic [7:0]       background_q;
  cfg_t             cfg;
  logic             push_valid;
  logic             push_ready;
  op_t              push_data;
  logic             pop_valid;
  logic             pop_ready;
  op_t              pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= SizeW'(MaxSide);
      height_q     <= SizeW'(MaxSide);
      background_q <= 8'd32;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgWidth:      width_q      <= cfg_i.data;
        CfgHeight:     height_q     <= cfg_i.data;
        CfgBackground: background_q <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.width      = side_in_use(width_q);
  assign cfg.height     = side_in_use(height_q);
  assign cfg.background = background_q;

  rrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rrp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

// ----- src/rrp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_front
// Accepts commands, checks them and turns them into decoded operations.
// ----------------------------------------------------------------------------
module rrp_front
  import rrp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  rrp_cmd_if.sink    cmd_i,
  output logic       push_valid_o,
  input  wire logic  push_ready_i,
  output op_t        push_data_o
);

  logic signed [FixW:0] x_lo_sum;
  logic signed [FixW:0] x_hi_sum;
  logic signed [FixW:0] y_lo_sum;
  logic signed [FixW:0] y_hi_sum;
  logic                 shape_ok;
  logic                 size_ok;
  logic                 read_ok;
  op_t                  op;

  // ceil(v/256) is (v+255) >> 8, floor is v >> 8: upper bits of the sums
  assign x_lo_sum = (FixW+1)'(cmd_i.rect_x) + (FixW+1)'(255);
  assign y_lo_sum = (FixW+1)'(cmd_i.rect_y) + (FixW+1)'(255);
  assign x_hi_sum = (FixW+1)'(cmd_i.rect_x) + (FixW+1)'(cmd_i.rect_width);
  assign y_hi_sum = (FixW+1)'(cmd_i.rect_y) + (FixW+1)'(cmd_i.rect_height);

  assign shape_ok = (cmd_i.shape_kind == ShapeOutline) ||
                    (cmd_i.shape_kind == ShapeFilled);
  assign size_ok  = !cmd_i.rect_width[FixW-1] && (cmd_i.rect_width != '0) &&
                    !cmd_i.rect_height[FixW-1] && (cmd_i.rect_height != '0);
  assign read_ok  = ({1'b0, cmd_i.pixel_col} < cfg_i.width) &&
                    ({1'b0, cmd_i.pixel_row} < cfg_i.height);

  always_comb begin
    op         = '0;
    op.kind    = OpReply;
    op.status  = StatusOk;
    op.outline = (cmd_i.shape_kind == ShapeOutline);
    op.paint   = cmd_i.paint_byte;
    op.x_lo    = x_lo_sum[FixW:8];
    op.x_hi    = x_hi_sum[FixW:8];
    op.y_lo    = y_lo_sum[FixW:8];
    op.y_hi    = y_hi_sum[FixW:8];
    op.rd_addr = {cmd_i.pixel_row, cmd_i.pixel_col};
    case (cmd_i.command)
      CmdClear: begin
        op.kind  = OpClear;
        op.paint = cfg_i.background;
      end
      CmdDraw: begin
        if (shape_ok && size_ok) begin
          op.kind = OpDraw;
        end else begin
          op.status = StatusBadRect;
        end
      end
      CmdRead: begin
        if (read_ok) begin
          op.kind = OpRead;
        end else begin
          op.status = StatusOutRange;
        end
      end
      default: begin
        op.kind = OpReply;
      end
    endcase
  end

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;
  assign push_data_o  = op;

`ifndef SYNTHESIS
  a_push_is_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_ready_i && push_data_o.kind == OpDraw) |->
      (cmd_i.command == CmdDraw && shape_ok && size_ok))
    else $error("draw pushed for an invalid rectangle");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_data_o.kind == OpRead) |->
      ({1'b0, push_data_o.rd_addr[SideW-1:0]} < cfg_i.width))
    else $error("read op outside canvas");
  a_bad_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && cmd_i.command == CmdDraw && !shape_ok) |->
      (push_data_o.status == StatusBadRect))
    else $error("bad shape not flagged");
`endif

endmodule
`default_nettype wire

// ----- src/rrp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_queue
// Two-entry queue of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module rrp_queue
  import rrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire op_t  push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output op_t       pop_data_o
);

  op_t        entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count overflow");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step");
  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count missed a push");
`endif

endmodule
`default_nettype wire

// ----- src/rrp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_back
// Executes decoded operations on the canvas memory and returns one result
// per operation.
// ----------------------------------------------------------------------------
module rrp_back
  import rrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic pop_valid_i,
  output logic      pop_ready_o,
  input  wire op_t  pop_data_i,
  rrp_res_if.source res_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSweep = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StResp  = 3'd3;

  logic [2:0]               state_q, state_d;
  op_t                      op_q;
  logic [SideW-1:0]         col_q, col_d;
  logic [SideW-1:0]         row_q, row_d;
  logic [7:0]               canvas_mem [Depth];
  logic [7:0]               rd_data_q;
  logic [SideW-1:0]         last_col;
  logic [SideW-1:0]         last_row;
  logic [SideW-1:0]         draw_last_col;
  logic signed [CoordW-1:0] px;
  logic signed [CoordW-1:0] py;
  logic                     covered;
  logic                     border;
  logic                     mem_we;
  logic                     sweep_done;

  assign draw_last_col = SideW'(cfg_i.width - SizeW'(1));
  assign last_col = (op_q.kind == OpClear) ? SideW'(MaxSide - 1) : draw_last_col;
  assign last_row = (op_q.kind == OpClear) ? SideW'(MaxSide - 1)
                                           : SideW'(cfg_i.height - SizeW'(1));

  assign px = $signed({(CoordW-SideW)'(0), col_q});
  assign py = $signed({(CoordW-SideW)'(0), row_q});

  assign covered = (px >= op_q.x_lo) && (px <= op_q.x_hi) &&
                   (py >= op_q.y_lo) && (py <= op_q.y_hi);
  assign border  = covered && ((px == op_q.x_lo) || (px == op_q.x_hi) ||
                               (py == op_q.y_lo) || (py == op_q.y_hi));

  always_comb begin
    mem_we = 1'b0;
    if (state_q == StSweep) begin
      if (op_q.kind == OpClear) begin
        mem_we = 1'b1;
      end else begin
        mem_we = op_q.outline ? border : covered;
      end
    end
  end

  assign sweep_done  = (col_q == last_col) && (row_q == last_row);
  assign pop_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    case (state_q)
      StIdle: begin
        col_d = '0;
        row_d = '0;
        if (pop_valid_i) begin
          case (pop_data_i.kind)
            OpClear, OpDraw: state_d = StSweep;
            OpRead:          state_d = StRead;
            default:         state_d = StResp;
          endcase
        end
      end
      StSweep: begin
        if (col_q == last_col) begin
          col_d = '0;
          row_d = row_q + SideW'(1);
          if (sweep_done) begin
            state_d = StResp;
          end
        end else begin
          col_d = col_q + SideW'(1);
        end
      end
      StRead: begin
        state_d = StResp;
      end
      StResp: begin
        if (res_o.ready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && pop_valid_i) begin
      op_q <= pop_data_i;
    end
  end

  // canvas: one write port for sweeps, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[{row_q, col_q}] <= op_q.paint;
    end
    if (state_q == StRead) begin
      rd_data_q <= canvas_mem[op_q.rd_addr];
    end
  end

  assign res_o.valid       = (state_q == StResp);
  assign res_o.status      = op_q.status;
  assign res_o.pixel_value = (op_q.kind == OpRead) ? rd_data_q : 8'd0;

`ifndef SYNTHESIS
  a_resp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready) |=> (state_q == StIdle))
    else $error("back end did not return to idle after a result");
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep && sweep_done) |=> (state_q == StResp && res_o.valid))
    else $error("sweep did not end in a result");
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |=> (state_q == StResp))
    else $error("read result late");
  a_draw_in_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep && op_q.kind == OpDraw) |->
      ({1'b0, col_q} < cfg_i.width && {1'b0, row_q} < cfg_i.height))
    else $error("draw sweep left the canvas");
  a_no_write_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StSweep) |-> !mem_we)
    else $error("canvas written outside a sweep");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_rectangle_raster_painter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rectangle_raster_painter
// Self-checking bench for the rectangle raster painter. A canvas mirror in
// the bench predicts every reply. Directed clears, draws and reads run under
// several canvas sizes and background bytes, then random command streams.
// Replies are compared in order, field by field, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_rectangle_raster_painter;
  timeunit 1ns;
  timeprecision 1ps;
  import rrp_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         HoldCycles = 300;
  localparam int         TrailCycles = 50;
  localparam int         RunLimitNs = 4_000_000;

  typedef struct {
    logic [1:0]         command;
    logic [7:0]         shape;
    logic signed [19:0] rx;
    logic signed [19:0] ry;
    logic signed [19:0] rw;
    logic signed [19:0] rh;
    logic [7:0]         paint;
    logic [7:0]         col;
    logic [7:0]         row;
  } paint_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] pixel;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  rrp_cmd_if cmd_bus ();
  rrp_res_if res_bus ();
  rrp_cfg_if cfg_bus ();

  rectangle_raster_painter u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  // canvas mirror and register copies
  logic [7:0]       canvas_img [Depth];
  logic [SizeW-1:0] cfg_width;
  logic [SizeW-1:0] cfg_height;
  logic [7:0]       cfg_background;

  paint_cmd_t  queued_cmds [$];
  paint_cmd_t  cmd_on_bus;
  reply_t      awaited_replies [$];
  reply_t      oldest_reply;
  int unsigned cmds_issued;
  int unsigned replies_seen;
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_start;
  int unsigned hold_left;

  function automatic int unsigned clamp_span(logic [SizeW-1:0] v);
    if (v == '0) return 1;
    if (v > SizeW'(MaxSide)) return MaxSide;
    return int'(v);
  endfunction

  // Applies one command to the mirror and returns the reply it must give.
  function automatic reply_t paint_outcome(paint_cmd_t c);
    reply_t      r;
    int unsigned cols;
    int unsigned rows;
    longint      left, top, right, bottom, px, py;
    bit          covered, border;
    r.status = StatusOk;
    r.pixel  = '0;
    cols = clamp_span(cfg_width);
    rows = clamp_span(cfg_height);
    case (c.command)
      CmdClear: begin
        foreach (canvas_img[i]) canvas_img[i] = cfg_background;
      end
      CmdDraw: begin
        left   = c.rx;
        top    = c.ry;
        right  = left + longint'(c.rw);
        bottom = top + longint'(c.rh);
        if ((c.shape != ShapeOutline && c.shape != ShapeFilled) ||
            c.rw <= 0 || c.rh <= 0) begin
          r.status = StatusBadRect;
        end else begin
          for (int unsigned y = 0; y < rows; y++) begin
            for (int unsigned x = 0; x < cols; x++) begin
              px = longint'(x) * 256;
              py = longint'(y) * 256;
              covered = px >= left && px <= right && py >= top && py <= bottom;
              // border band: closer than 1.0 to any edge
              border = covered && (px - left < 256 || right - px < 256 ||
                                   py - top < 256 || bottom - py < 256);
              if ((c.shape == ShapeFilled && covered) ||
                  (c.shape == ShapeOutline && border)) begin
                canvas_img[y * MaxSide + x] = c.paint;
              end
            end
          end
        end
      end
      CmdRead: begin
        if (c.col >= cols || c.row >= rows) begin
          r.status = StatusOutRange;
        end else begin
          r.pixel = canvas_img[int'(c.row) * MaxSide + int'(c.col)];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic paint_cmd_t scrambled_cmd(logic [1:0] command);
    paint_cmd_t c;
    c.command = command;
    c.shape   = 8'($urandom);
    c.rx      = 20'($urandom);
    c.ry      = 20'($urandom);
    c.rw      = 20'($urandom);
    c.rh      = 20'($urandom);
    c.paint   = 8'($urandom);
    c.col     = 8'($urandom);
    c.row     = 8'($urandom);
    return c;
  endfunction

  // Mostly well-formed draws and reads sized to the canvas in use, up to one past its last column and row.
  function automatic paint_cmd_t pick_random_cmd();
    paint_cmd_t  c;
    int unsigned cols;
    int unsigned rows;
    int unsigned roll;
    cols = clamp_span(cfg_width);
    rows = clamp_span(cfg_height);
    roll = $urandom_range(99);
    c = scrambled_cmd(CmdDraw);
    if (roll < 45) begin
      c.shape = $urandom_range(1) ? ShapeFilled : ShapeOutline;
      c.rx = 20'(int'($urandom_range((cols + 8) * 256)) - 1024);
      c.ry = 20'(int'($urandom_range((rows + 8) * 256)) - 1024);
      c.rw = 20'(1 + $urandom_range((cols + 4) * 256));
      c.rh = 20'(1 + $urandom_range((rows + 4) * 256));
    end else if (roll < 85) begin
      c.command = CmdRead;
      c.col = 8'($urandom_range(cols < 255 ? cols : 255));
      c.row = 8'($urandom_range(rows < 255 ? rows : 255));
    end else if (roll < 93) begin
      // raw draw: random shape byte and random geometry
    end else if (roll < 97) begin
      c.command = CmdUnused;
    end else begin
      c.command = CmdRead;
    end
    return c;
  endfunction

  task automatic push_cmd(paint_cmd_t c);
    queued_cmds.push_back(c);
    cmds_issued++;
  endtask

  task automatic push_draw(logic [7:0] shape, int x, int y, int w, int h,
                           logic [7:0] paint);
    paint_cmd_t c;
    c = scrambled_cmd(CmdDraw);
    c.shape = shape;
    c.rx    = 20'(x);
    c.ry    = 20'(y);
    c.rw    = 20'(w);
    c.rh    = 20'(h);
    c.paint = paint;
    push_cmd(c);
  endtask

  task automatic push_read(int col, int row);
    paint_cmd_t c;
    c = scrambled_cmd(CmdRead);
    c.col = 8'(col);
    c.row = 8'(row);
    push_cmd(c);
  endtask

  task automatic push_random(int n);
    repeat (n) push_cmd(pick_random_cmd());
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (replies_seen < cmds_issued);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [8:0] data);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i);
    while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    case (idx)
      CfgWidth:      cfg_width = data;
      CfgHeight:     cfg_height = data;
      CfgBackground: cfg_background = data[7:0];
      default: ;
    endcase
  endtask

  task automatic flag_error(string msg);
    $display("%0t ERROR %s", $realtime, msg);
    error_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // command driver: predicts each transaction as it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        awaited_replies.push_back(paint_outcome(cmd_on_bus));
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = queued_cmds.pop_front();
          cmd_bus.valid       <= 1'b1;
          cmd_bus.command     <= cmd_on_bus.command;
          cmd_bus.shape_kind  <= cmd_on_bus.shape;
          cmd_bus.rect_x      <= cmd_on_bus.rx;
          cmd_bus.rect_y      <= cmd_on_bus.ry;
          cmd_bus.rect_width  <= cmd_on_bus.rw;
          cmd_bus.rect_height <= cmd_on_bus.rh;
          cmd_bus.paint_byte  <= cmd_on_bus.paint;
          cmd_bus.pixel_col   <= cmd_on_bus.col;
          cmd_bus.pixel_row   <= cmd_on_bus.row;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // reply monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (awaited_replies.size() == 0) begin
          flag_error($sformatf("reply %0d arrived with nothing outstanding",
                               replies_seen));
        end else begin
          oldest_reply = awaited_replies.pop_front();
          if (res_bus.status !== oldest_reply.status) begin
            flag_error($sformatf("reply %0d: status %0d, expected %0d", replies_seen,
                                 res_bus.status, oldest_reply.status));
          end
          if (res_bus.pixel_value !== oldest_reply.pixel) begin
            flag_error($sformatf("reply %0d: pixel 0x%02h, expected 0x%02h",
                                 replies_seen, res_bus.pixel_value,
                                 oldest_reply.pixel));
          end
        end
        replies_seen++;
      end
      res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.command       = CmdClear;
    cmd_bus.shape_kind    = '0;
    cmd_bus.rect_x        = '0;
    cmd_bus.rect_y        = '0;
    cmd_bus.rect_width    = '0;
    cmd_bus.rect_height   = '0;
    cmd_bus.paint_byte    = '0;
    cmd_bus.pixel_col     = '0;
    cmd_bus.pixel_row     = '0;
    res_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CfgWidth;
    cfg_bus.data          = '0;
    hold_start            = 1'b0;
    send_idle_pct         = 26;
    recv_idle_pct         = 60;
    cfg_width             = 9'd256;
    cfg_height            = 9'd256;
    cfg_background        = 8'd32;
    cmds_issued           = 0;
    replies_seen          = 0;
    error_count           = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full canvas; bit 8 of the background write is dropped
    write_reg(CfgWidth, 9'd256);
    write_reg(CfgHeight, 9'd256);
    write_reg(CfgBackground, 9'h100);
    push_cmd(scrambled_cmd(CmdClear));
    push_read(0, 0);
    push_read(255, 255);
    push_draw(ShapeFilled, -2560, -2560, 524287, 524287, 8'hFF);
    push_read(128, 77);
    push_draw(8'h00, 0, 0, 256, 256, 8'h11);
    push_draw(ShapeOutline, 0, 0, 0, 256, 8'h22);
    push_draw(ShapeFilled, 0, 0, 256, -524288, 8'h33);
    push_cmd(scrambled_cmd(CmdUnused));
    push_read(255, 0);
    wait_quiet();

    // width 0 acts as one column, height 511 saturates
    write_reg(CfgWidth, 9'd0);
    write_reg(CfgHeight, 9'd511);
    write_reg(CfgBackground, 9'h0FF);
    push_cmd(scrambled_cmd(CmdClear));
    push_read(0, 255);
    push_read(1, 0);
    push_draw(ShapeFilled, 524287, 524287, 524287, 524287, 8'h44);
    push_draw(ShapeFilled, -524288, 0, 524287, 256, 8'h55);
    push_draw(ShapeFilled, 0, 0, 1, 1, 8'h01);
    push_read(0, 0);
    wait_quiet();

    send_idle_pct <= 60;
    recv_idle_pct <= 26;
    write_reg(CfgWidth, 9'd13);
    write_reg(CfgHeight, 9'd9);
    write_reg(CfgBackground, 9'($urandom_range(511)));
    push_cmd(scrambled_cmd(CmdClear));
    // outline 1.5,1.0 size 5.0x4.0: (4,3) is interior and keeps background
    push_draw(ShapeOutline, 384, 256, 1280, 1024, 8'hC3);
    push_read(2, 3);
    push_read(4, 3);
    push_read(6, 5);
    push_read(7, 3);
    push_draw(ShapeFilled, 2304, 1536, 896, 512, 8'h3C);
    push_read(12, 8);
    push_read(13, 8);
    push_random(15);
    wait_quiet();

    // receiver holds off while reads keep coming, so the input backs up
    hold_start    <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (12) push_read($urandom_range(12), $urandom_range(8));
    wait_quiet();
    push_cmd(scrambled_cmd(CmdClear));
    push_random(15);
    wait_quiet();

    // one row of 256 columns, no idling from here on
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_reg(CfgWidth, 9'd300);
    write_reg(CfgHeight, 9'd1);
    write_reg(CfgBackground, 9'($urandom_range(511)));
    push_cmd(scrambled_cmd(CmdClear));
    push_read(255, 0);
    push_read(0, 1);
    push_random(12);
    wait_quiet();

    // no clear: rows below 0 must still hold the last background
    write_reg(CfgWidth, 9'($urandom_range(24, 2)));
    write_reg(CfgHeight, 9'($urandom_range(24, 2)));
    write_reg(CfgBackground, 9'($urandom_range(511)));
    push_random(20);
    wait_quiet();

    repeat (TrailCycles) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      flag_error($sformatf("%0d replies never arrived", awaited_replies.size()));
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("%0t ERROR run limit reached", $realtime);
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
